FILE: rtl/core/rc4_stream_cipher_defines.svh
// Assertion macros for the RC4 core.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RC4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RC4_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/rc4_pkg.sv
`timescale 1ns / 1ps
package rc4_pkg;

    localparam int KEY_BYTES_MAX = 16;
    localparam int KEY_W         = 8 * KEY_BYTES_MAX;
    localparam int PERM_DEPTH    = 256;
    localparam int BYTE_W        = 8;
    localparam int KLEN_W        = 5;
    localparam int SKIP_W        = 16;
    localparam int KPOS_W        = $clog2(KEY_BYTES_MAX) > 0 ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 64;

    localparam logic [1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] REG_KEY_LENGTH = 2'd2;
    localparam logic [1:0] REG_SKIP_COUNT = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [KLEN_W-1:0] key_len;
        logic [SKIP_W-1:0] skip;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [BYTE_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [BYTE_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic busy;
        logic keyed;
    } t_status;

endpackage

FILE: rtl/core/rc4_ram.sv
`timescale 1ns / 1ps
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/core/rc4_cfg.sv
`timescale 1ns / 1ps
module rc4_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rc4_pkg::PADDR_W-1:0]    paddr,
    input  logic [rc4_pkg::PDATA_W-1:0]    pwdata,
    output logic [rc4_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output rc4_pkg::t_cfg                  o_cfg
);

    import rc4_pkg::*;

    logic [63:0]       r_key_low;
    logic [63:0]       r_key_high;
    logic [KLEN_W-1:0] r_key_length;
    logic [SKIP_W-1:0] r_skip_count;
    logic              wr_en;
    logic [1:0]        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_key_length <= KLEN_W'(5);
            r_skip_count <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_KEY_LOW:    r_key_low    <= pwdata;
                REG_KEY_HIGH:   r_key_high   <= pwdata;
                REG_KEY_LENGTH: r_key_length <= pwdata[KLEN_W-1:0];
                REG_SKIP_COUNT: r_skip_count <= pwdata[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_KEY_LOW:    prdata = r_key_low;
            REG_KEY_HIGH:   prdata = r_key_high;
            REG_KEY_LENGTH: prdata = {{(PDATA_W-KLEN_W){1'b0}}, r_key_length};
            REG_SKIP_COUNT: prdata = {{(PDATA_W-SKIP_W){1'b0}}, r_skip_count};
            default:        prdata = '0;
        endcase
    end

    // Clamp length: zero counts as one, saturate at the key size.
    always_comb begin
        o_cfg.key  = {r_key_high, r_key_low};
        o_cfg.skip = r_skip_count;
        if (r_key_length == '0) begin
            o_cfg.key_len = KLEN_W'(1);
        end else if (r_key_length > KLEN_W'(KEY_BYTES_MAX)) begin
            o_cfg.key_len = KLEN_W'(KEY_BYTES_MAX);
        end else begin
            o_cfg.key_len = r_key_length;
        end
    end

endmodule

FILE: rtl/core/rc4_ctrl.sv
`timescale 1ns / 1ps
module rc4_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rc4_pkg::t_cfg              i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rc4_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_start_message,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [rc4_pkg::BYTE_W-1:0] o_out_byte,
    output rc4_pkg::t_ram_req          o_ram,
    input  logic [rc4_pkg::BYTE_W-1:0] i_ram_rdata,
    output rc4_pkg::t_status           o_status
);

    import rc4_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_RDI  = 3'd2;
    localparam logic [2:0] ST_GETI = 3'd3;
    localparam logic [2:0] ST_GETJ = 3'd4;
    localparam logic [2:0] ST_WRJ  = 3'd5;
    localparam logic [2:0] ST_OUTP = 3'd6;

    localparam logic [BYTE_W-1:0] IDX_LAST = 8'hff;

    logic [2:0]        r_state, n_state;
    logic [BYTE_W-1:0] r_i, n_i;
    logic [BYTE_W-1:0] r_j, n_j;
    logic [BYTE_W-1:0] r_si, n_si;
    logic [BYTE_W-1:0] r_sj, n_sj;
    logic [KPOS_W-1:0] r_kpos, n_kpos;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic              r_ksa, n_ksa;
    logic              r_emit, n_emit;
    logic              r_fwd, n_fwd;
    logic              r_keyed, n_keyed;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [BYTE_W-1:0] r_data, n_data;

    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] j_new;
    logic [BYTE_W-1:0] sum_idx;
    logic [BYTE_W-1:0] ks_byte;

    assign key_byte = i_cfg.key[{r_kpos, 3'b000} +: BYTE_W];
    assign j_new    = r_j + i_ram_rdata + (r_ksa ? key_byte : '0);
    assign sum_idx  = r_si + r_sj;
    assign ks_byte  = r_fwd ? r_si : i_ram_rdata;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_status.busy  = (r_state != ST_IDLE);
    assign o_status.keyed = r_keyed;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_si        = r_si;
        n_sj        = r_sj;
        n_kpos      = r_kpos;
        n_skip      = r_skip;
        n_ksa       = r_ksa;
        n_emit      = r_emit;
        n_fwd       = r_fwd;
        n_keyed     = r_keyed;
        n_out_byte  = r_out_byte;
        n_data      = r_data;
        n_out_valid = r_out_valid & ~i_out_ready;

        o_ram.we    = 1'b0;
        o_ram.re    = 1'b1;
        o_ram.waddr = r_i;
        o_ram.wdata = r_si;
        o_ram.raddr = r_i;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_data = i_data_byte;
                    if (i_start_message || !r_keyed) begin
                        n_i     = '0;
                        n_state = ST_FILL;
                    end else begin
                        n_ksa   = 1'b0;
                        n_emit  = 1'b1;
                        n_state = ST_RDI;
                    end
                end
            end
            ST_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_i;
                o_ram.wdata = r_i;
                n_i         = r_i + BYTE_W'(1);
                if (r_i == IDX_LAST) begin
                    n_ksa   = 1'b1;
                    n_j     = '0;
                    n_kpos  = '0;
                    n_state = ST_RDI;
                end
            end
            ST_RDI: begin
                if (r_ksa) begin
                    o_ram.raddr = r_i;
                end else begin
                    o_ram.raddr = r_i + BYTE_W'(1);
                    n_i         = r_i + BYTE_W'(1);
                end
                n_state = ST_GETI;
            end
            ST_GETI: begin
                n_j         = j_new;
                n_si        = i_ram_rdata;
                o_ram.raddr = j_new;
                n_state     = ST_GETJ;
            end
            ST_GETJ: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_i;
                o_ram.wdata = i_ram_rdata;
                n_sj        = i_ram_rdata;
                n_state     = ST_WRJ;
            end
            ST_WRJ: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_j;
                o_ram.wdata = r_si;
                o_ram.raddr = sum_idx;
                // The read sees the old entry when it hits the slot written now.
                n_fwd       = (sum_idx == r_j);
                n_state     = ST_RDI;
                if (r_ksa) begin
                    if (KLEN_W'({1'b0, r_kpos}) + KLEN_W'(1) >= i_cfg.key_len) begin
                        n_kpos = '0;
                    end else begin
                        n_kpos = r_kpos + KPOS_W'(1);
                    end
                    n_i = r_i + BYTE_W'(1);
                    if (r_i == IDX_LAST) begin
                        n_ksa   = 1'b0;
                        n_i     = '0;
                        n_j     = '0;
                        n_keyed = 1'b1;
                        n_skip  = i_cfg.skip;
                        n_emit  = (i_cfg.skip == '0);
                    end
                end else if (r_emit) begin
                    n_state = ST_OUTP;
                end else begin
                    n_skip = r_skip - SKIP_W'(1);
                    n_emit = (r_skip == SKIP_W'(1));
                end
            end
            ST_OUTP: begin
                o_ram.re = 1'b0;
                if (!r_out_valid || i_out_ready) begin
                    n_out_byte  = r_data ^ ks_byte;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_kpos      <= '0;
            r_skip      <= '0;
            r_ksa       <= 1'b0;
            r_emit      <= 1'b0;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_kpos      <= n_kpos;
            r_skip      <= n_skip;
            r_ksa       <= n_ksa;
            r_emit      <= n_emit;
            r_keyed     <= n_keyed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_fwd      <= n_fwd;
        r_out_byte <= n_out_byte;
        r_data     <= n_data;
    end

endmodule

FILE: rtl/core/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// RC4 byte cipher with optional discard of the first keystream bytes.
// Input channel (i_in_valid / o_in_ready) carries one data byte and a
// start-of-message flag per transaction; output channel (o_out_valid /
// i_out_ready) returns one byte per input: data XOR next keystream byte.
// Key, key length and skip count are written over the APB port while idle;
// keeping to that is the user's duty, as the block itself leaves it unchecked.
// A plain byte steps through read i, read j, the two write-backs and the
// output read, all set by the single read and single write port of the
// 256x8 permutation memory. At most one byte is in flight and the next is
// taken the cycle after the result is loaded.
// A byte with the start flag, and the first byte after reset, first rebuilds
// the permutation: the fill pass, the key schedule over all 256 entries,
// then skip_count discarded keystream bytes, before its own step.
// Reset clears indices, the keyed flag and the output valid; the permutation
// memory is left as is and is always refilled before first use.
// When the receiver stalls, the finished byte holds in the output register
// and the next input transaction is still taken; a second result then holds
// in the sequencer until the register frees.
module rc4_stream_cipher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_start_message,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rc4_pkg::PADDR_W-1:0]    paddr,
    input  logic [rc4_pkg::PDATA_W-1:0]    pwdata,
    output logic [rc4_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    import rc4_pkg::*;

`include "rc4_stream_cipher_defines.svh"

    t_cfg              cfg;
    t_ram_req          ram_req;
    t_status           status;
    logic [BYTE_W-1:0] ram_rdata;
    logic              in_hs;

    assign in_hs = i_in_valid & o_in_ready;

    // Register file: key, clamped key length and skip count.
    rc4_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer: fill, key schedule, discard and per-byte swap steps.
    rc4_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_start_message (i_start_message),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_ram           (ram_req),
        .i_ram_rdata     (ram_rdata),
        .o_status        (status)
    );

    // Permutation store: one write and one registered read per cycle.
    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // An accepted byte always keeps the sequencer busy for the next cycle.
    `RC4_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_hs, status.busy)
    // No result may appear before the permutation has been scheduled.
    `RC4_ASSERT_IMP(a_no_out_unkeyed, i_clk, i_rst_n, !status.keyed, !o_out_valid)
    // A new result is only loaded as the sequencer finishes a byte.
    `RC4_ASSERT_IMP(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(status.busy))
    // The memory is never written while idle.
    `RC4_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, !status.busy, !ram_req.we)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// RC4 stream cipher bench. The stimulus initial block fills a queue of
// pending byte transactions. A clocked driver presents them on the input
// channel. A clocked monitor takes results off the output channel and checks
// each one in order against the keystream model held below. Register writes
// go over the APB port only while the block is drained.
module tb_top;
    import rc4_pkg::*;

    typedef struct packed {
        logic       hold;   // wait until every earlier byte has come back
        logic       start;
        logic [7:0] data;
    } t_byte_txn;

    // Clock, reset and block ports. Everything starts at a known value.
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_ready;
    logic [7:0]          i_data_byte     = '0;
    logic                i_start_message = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready     = 1'b0;
    logic [7:0]          o_out_byte;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [PADDR_W-1:0]  paddr           = '0;
    logic [PDATA_W-1:0]  pwdata          = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow of the configuration registers, at their reset values.
    logic [63:0]         cfg_key_low     = '0;
    logic [63:0]         cfg_key_high    = '0;
    logic [KLEN_W-1:0]   cfg_key_len     = 5'd5;
    logic [SKIP_W-1:0]   cfg_skip        = '0;

    // Keystream model state.
    logic [7:0]          rc4_perm [PERM_DEPTH];
    logic [7:0]          rc4_i           = '0;
    logic [7:0]          rc4_j           = '0;
    logic                rc4_keyed       = 1'b0;

    t_byte_txn           pending_bytes [$];
    logic [7:0]          expected_bytes [$];
    int                  accept_cnt      = 0;
    int                  done_cnt        = 0;
    int                  mismatch_cnt    = 0;
    int unsigned         send_idle_pct   = 0;
    int unsigned         recv_idle_pct   = 0;

    rc4_stream_cipher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_start_message (i_start_message),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Keystream model
    // ------------------------------------------------------------------
    function automatic logic [7:0] key_byte_at(input int unsigned n);
        if (n < 8)
            return cfg_key_low[8*n +: 8];
        return cfg_key_high[8*(n-8) +: 8];
    endfunction

    // Advance both indices, swap, and return the next keystream byte.
    function automatic logic [7:0] keystream_byte();
        logic [7:0] t;
        logic [7:0] sum;
        rc4_i = rc4_i + 8'd1;
        rc4_j = rc4_j + rc4_perm[rc4_i];
        t = rc4_perm[rc4_i];
        rc4_perm[rc4_i] = rc4_perm[rc4_j];
        rc4_perm[rc4_j] = t;
        sum = rc4_perm[rc4_i] + rc4_perm[rc4_j];
        return rc4_perm[sum];
    endfunction

    // Rebuild the permutation from the key, clear the indices, then drop
    // skip_count keystream bytes.
    function automatic void rekey_perm();
        int unsigned len;
        int unsigned kpos;
        int unsigned n;
        logic [7:0]  j;
        logic [7:0]  t;
        logic [7:0]  dropped;
        len = cfg_key_len;
        // A zero length behaves as one byte; anything past the key store
        // saturates.
        if (len == 0)
            len = 1;
        if (len > KEY_BYTES_MAX)
            len = KEY_BYTES_MAX;
        for (n = 0; n < PERM_DEPTH; n++)
            rc4_perm[n] = n[7:0];
        j = '0;
        kpos = 0;
        for (n = 0; n < PERM_DEPTH; n++) begin
            j = j + rc4_perm[n] + key_byte_at(kpos);
            kpos++;
            if (kpos >= len)
                kpos = 0;
            t = rc4_perm[n];
            rc4_perm[n] = rc4_perm[j];
            rc4_perm[j] = t;
        end
        rc4_i = '0;
        rc4_j = '0;
        for (n = 0; n < cfg_skip; n++)
            dropped = keystream_byte();
        rc4_keyed = 1'b1;
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic start);
        if (start || !rc4_keyed)
            rekey_perm();
        return data ^ keystream_byte();
    endfunction

    task automatic report_mismatch(input string what);
        // Cap the printout; keep counting regardless.
        if (mismatch_cnt < 40)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Driver: present pending transactions on the input channel, predict
    // each one as it is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic      taken;
        logic      blocked;
        t_byte_txn txn;
        taken = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_bytes.push_back(cipher_byte(i_data_byte, i_start_message));
                accept_cnt <= accept_cnt + 1;
                taken = 1'b1;
            end
            if (!i_in_valid || taken) begin
                // A held transaction waits until nothing is outstanding.
                blocked = pending_bytes.size() > 0 && pending_bytes[0].hold &&
                          (accept_cnt + int'(taken) != done_cnt);
                if (pending_bytes.size() > 0 && !blocked &&
                    $urandom_range(99) >= send_idle_pct) begin
                    txn = pending_bytes.pop_front();
                    i_in_valid      <= 1'b1;
                    i_data_byte     <= txn.data;
                    i_start_message <= txn.start;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results, compare with the oldest prediction, and
    // stall the output channel at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (done_cnt == accept_cnt) begin
                    report_mismatch($sformatf("result 0x%02h with no byte outstanding",
                                              o_out_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want)
                        report_mismatch($sformatf("byte %0d: out_byte 0x%02h, want 0x%02h",
                                                  done_cnt, o_out_byte, want));
                    done_cnt <= done_cnt + 1;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] data, input logic start, input logic hold);
        t_byte_txn txn;
        txn.hold  = hold;
        txn.start = start;
        txn.data  = data;
        pending_bytes.push_back(txn);
    endtask

    // Hold until every queued transaction is taken and every result is back.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || accept_cnt != done_cnt);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready is seen.
    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_LOW:    cfg_key_low  = value;
            REG_KEY_HIGH:   cfg_key_high = value;
            REG_KEY_LENGTH: cfg_key_len  = value[KLEN_W-1:0];
            REG_SKIP_COUNT: cfg_skip     = value[SKIP_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // New random setting; upper bits of the narrow registers carry junk.
    task automatic random_config();
        logic [63:0] v;
        cfg_write(REG_KEY_LOW, rand64());
        cfg_write(REG_KEY_HIGH, rand64());
        v = rand64();
        case ($urandom_range(7))
            0:       v[KLEN_W-1:0] = '0;
            1:       v[KLEN_W-1:0] = KLEN_W'($urandom_range(31, 17));
            default: v[KLEN_W-1:0] = KLEN_W'($urandom_range(16, 1));
        endcase
        cfg_write(REG_KEY_LENGTH, v);
        v = rand64();
        // Mostly short discards, now and then a longer one.
        if ($urandom_range(9) == 0)
            v[SKIP_W-1:0] = SKIP_W'($urandom_range(1500, 41));
        else
            v[SKIP_W-1:0] = SKIP_W'($urandom_range(40));
        cfg_write(REG_SKIP_COUNT, v);
    endtask

    // Messages of random length with random content, a few stray start
    // flags, and one transaction that waits for the block to drain.
    task automatic fill_batch(input int n);
        int         k;
        int         msg_left;
        int         hold_at;
        logic       start;
        logic [7:0] data;
        hold_at  = $urandom_range(n - 1, 1);
        msg_left = $urandom_range(30, 1);
        for (k = 0; k < n; k++) begin
            if (k == 0) begin
                // Sometimes carry on the old message across the new setting.
                start = ($urandom_range(3) != 0);
            end else if (msg_left == 0) begin
                start    = 1'b1;
                msg_left = $urandom_range(30, 1);
            end else begin
                start = ($urandom_range(19) == 0);
            end
            msg_left--;
            case ($urandom_range(9))
                0:       data = 8'h00;
                1:       data = 8'hff;
                default: data = 8'($urandom);
            endcase
            queue_byte(data, start, k == hold_at);
        end
    endtask

    initial begin
        int ph;
        int b;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 63;

        // Reset setting; the first byte keys the block without a start flag.
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b0);
        queue_byte(8'h5a, 1'b1, 1'b0);
        wait_idle();

        // All-ones key at full length.
        cfg_write(REG_KEY_LOW, '1);
        cfg_write(REG_KEY_HIGH, '1);
        cfg_write(REG_KEY_LENGTH, 64'd16);
        queue_byte(8'hff, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        wait_idle();

        // Zero key length falls back to key byte 0 alone.
        cfg_write(REG_KEY_LENGTH, 64'd0);
        cfg_write(REG_KEY_LOW, rand64());
        queue_byte(8'($urandom), 1'b1, 1'b0);
        queue_byte(8'($urandom), 1'b0, 1'b0);
        wait_idle();

        // Over-long key length saturates.
        cfg_write(REG_KEY_LENGTH, 64'd31);
        cfg_write(REG_KEY_HIGH, rand64());
        queue_byte(8'($urandom), 1'b1, 1'b0);
        queue_byte(8'($urandom), 1'b0, 1'b0);
        wait_idle();

        // Largest discard, once only.
        cfg_write(REG_KEY_LENGTH, 64'd17);
        cfg_write(REG_SKIP_COUNT, 64'hffff);
        queue_byte(8'($urandom), 1'b1, 1'b0);
        queue_byte(8'($urandom), 1'b0, 1'b1);
        wait_idle();

        // Shortest key, zero key bytes, single discard.
        cfg_write(REG_KEY_LOW, '0);
        cfg_write(REG_KEY_LENGTH, 64'd1);
        cfg_write(REG_SKIP_COUNT, 64'd1);
        queue_byte(8'($urandom), 1'b1, 1'b0);
        wait_idle();

        // Change registers mid-message: old stream carries on until the
        // next start flag.
        cfg_write(REG_KEY_HIGH, rand64());
        cfg_write(REG_KEY_LENGTH, 64'hffff_ffff_ffff_ffe9);
        cfg_write(REG_SKIP_COUNT, 64'habcd_0000_0001_0003);
        queue_byte(8'($urandom), 1'b0, 1'b0);
        queue_byte(8'($urandom), 1'b0, 1'b0);
        queue_byte(8'($urandom), 1'b1, 1'b0);
        queue_byte(8'($urandom), 1'b0, 1'b0);
        wait_idle();

        // Random part: three idling regimes, three settings in each.
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (b = 0; b < 3; b++) begin
                random_config();
                fill_batch(106);
                wait_idle();
            end
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("** rc4_stream_cipher: PASSED **");
        else
            $display("** rc4_stream_cipher: FAILED **");
        $finish;
    end

    // Watchdog: a lost result or a hung channel ends up here.
    initial begin
        #100_000_000;
        $display("** rc4_stream_cipher: FAILED **");
        $finish;
    end

endmodule

FILE: rc4_stream_cipher.f
+incdir+rtl/core
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_cfg.sv
rtl/core/rc4_ctrl.sv
rtl/core/rc4_stream_cipher.sv
tb/tb_top.sv
